// ===== rtl/core/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangular/polar converter
// Fixed-point formats, mode codes, CORDIC arctangent table and stage records.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Field format: signed Q16.16
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // Internal formats: x/y carry extra fraction bits, angles run in degrees Q32
  localparam int GUARD_BITS = 8;
  localparam int ANG_FRAC   = 32;
  localparam int XY_W       = DATA_WIDTH + GUARD_BITS + 4;
  localparam int Z_W        = ANG_FRAC + 11;
  localparam int ANG_R_W    = Z_W - (ANG_FRAC - FRAC_BITS);
  localparam int MAX_ITER   = 32;

  // Mode codes
  localparam logic [1:0] FUNC_RECT  = 2'd0;
  localparam logic [1:0] FUNC_POLAR = 2'd1;

  // 1/K of the converged CORDIC gain, Q0.32
  localparam int          MUL_W    = 32;
  localparam logic [MUL_W-1:0] INV_GAIN = 32'd2608131496;

  // Angle constants, degrees in Q32
  localparam logic signed [Z_W-1:0] DEG90_Z     = Z_W'(64'sd90 << ANG_FRAC);
  localparam logic signed [Z_W-1:0] NEG_DEG90_Z = -DEG90_Z;
  localparam logic signed [Z_W-1:0] DEG180_Z    = Z_W'(64'sd180 << ANG_FRAC);
  localparam logic signed [Z_W-1:0] ROUND_Z     =
    Z_W'(64'sd1 << (ANG_FRAC - FRAC_BITS - 1));

  // Angle constants, degrees in field format
  localparam logic signed [ANG_R_W-1:0] HALF_R     = ANG_R_W'(64'sd180 << FRAC_BITS);
  localparam logic signed [ANG_R_W-1:0] NEG_HALF_R = -HALF_R;
  localparam logic signed [ANG_R_W-1:0] FULL_R     = ANG_R_W'(64'sd360 << FRAC_BITS);

  // Reduction mod 360 degrees: 360 * 2^FRAC_BITS = MOD_DIV * 2^MOD_SH
  localparam int MOD_SH = FRAC_BITS + 3;
  localparam int MOD_W  = DATA_WIDTH - MOD_SH;
  localparam int REM_W  = 6;
  localparam logic [MOD_W-1:0] MOD_DIV   = MOD_W'(45);
  localparam logic [MOD_W-1:0] MOD_RECIP = MOD_W'((64'd1 << MOD_W) / 64'd45);
  // 2^DATA_WIDTH mod 360 degrees, removed from negative inputs
  localparam logic signed [ANG_R_W-1:0] WRAP_OFF =
    ANG_R_W'((64'd1 << DATA_WIDTH) % (64'd360 << FRAC_BITS));

  // atan(2^-i) in degrees, Q32
  localparam logic [63:0] ATAN_DEG_Q32 [MAX_ITER] = '{
    64'd193273528320, 64'd114096026022, 64'd60285206654, 64'd30601712202,
    64'd15360239180,  64'd7687607525,   64'd3844741810,  64'd1922488225,
    64'd961258780,    64'd480631223,    64'd240315841,   64'd120157949,
    64'd60078978,     64'd30039489,     64'd15019745,    64'd7509872,
    64'd3754936,      64'd1877468,      64'd938734,      64'd469367,
    64'd234684,       64'd117342,       64'd58671,       64'd29335,
    64'd14668,        64'd7334,         64'd3667,        64'd1833,
    64'd917,          64'd458,          64'd229,         64'd115
  };

  typedef struct packed {
    logic [1:0]                   func;
    logic signed [DATA_WIDTH-1:0] first_value;
    logic signed [DATA_WIDTH-1:0] second_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_out;
    logic signed [DATA_WIDTH-1:0] y_out;
    logic signed [DATA_WIDTH-1:0] magnitude_out;
    logic signed [DATA_WIDTH-1:0] angle_out;
    logic                         mode_error;
  } out_item_t;

  typedef struct packed {
    logic rect;   // vectoring (rectangular input) when set, else rotation
    logic err;    // invalid mode
    logic zero;   // rectangular zero vector
  } ctl_t;

  typedef struct packed {
    ctl_t                         ctl;
    logic signed [DATA_WIDTH-1:0] a;
    logic signed [DATA_WIDTH-1:0] b;
    logic signed [XY_W-1:0]       x;
    logic signed [XY_W-1:0]       y;
    logic signed [Z_W-1:0]        z;
  } cordic_t;

endpackage

// ===== rtl/core/rect_polar_converter.sv =====
// ----------------------------------------------------------------------------
// rect_polar_converter: pipelined CORDIC rectangular <-> polar converter
// Rectangular input gives magnitude and atan2 angle in degrees; polar input
// gives the x and y components. Fields are signed Q16.16.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          payload
//  input     in         in_valid_i / in_ready_o          in_data_i  (in_item_t)
//  output    out        out_valid_o / out_ready_i        out_data_o (out_item_t)
//
//  One item enters per cycle while the output is not held; each passes 3 input
//  stages, one stage per CORDIC iteration and 4 output stages to the result.
//  Reset clears only the stage valid bits.
//  Every stage holds its item while the next stage is full and cannot move on, so
//  bubbles close up; while a result waits at the output, input transfers continue until all
//  ITERATIONS + 7 stages are full.
// ----------------------------------------------------------------------------
module rect_polar_converter #(
  parameter int ITERATIONS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpc_pkg::out_item_t out_data_o
);

  logic [ITERATIONS:0] stg_valid, stg_ready;
  rpc_pkg::cordic_t    stg_data [ITERATIONS+1];

  rpc_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (stg_valid[0]),
    .out_ready_i (stg_ready[0]),
    .out_data_o  (stg_data[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
    rpc_cordic_stage #(
      .IDX (i)
    ) u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[i]),
      .in_ready_o  (stg_ready[i]),
      .in_data_i   (stg_data[i]),
      .out_valid_o (stg_valid[i+1]),
      .out_ready_i (stg_ready[i+1]),
      .out_data_o  (stg_data[i+1])
    );
  end

  rpc_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (stg_valid[ITERATIONS]),
    .in_ready_o  (stg_ready[ITERATIONS]),
    .in_data_i   (stg_data[ITERATIONS]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/core/rpc_prep.sv =====
// ----------------------------------------------------------------------------
// rpc_prep: input conditioning for the CORDIC pipeline
// Three stages: mode decode and half-plane fold, angle reduction to
// (-180,180], quadrant fold for rotation.
// ----------------------------------------------------------------------------
module rpc_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpc_pkg::cordic_t   out_data_o
);

  localparam int DW     = rpc_pkg::DATA_WIDTH;
  localparam int XW     = rpc_pkg::XY_W;
  localparam int ZW     = rpc_pkg::Z_W;
  localparam int RW     = rpc_pkg::ANG_R_W;
  localparam int MW     = rpc_pkg::MOD_W;
  localparam int MSH    = rpc_pkg::MOD_SH;

  // stage 1
  logic                 s1_valid_q, s1_ready;
  rpc_pkg::cordic_t     s1_d, s1_q;
  logic [MW-1:0]        s1_rem_d, s1_rem_q;
  logic [MSH-1:0]       s1_low_q;
  logic                 s1_neg_q;
  // stage 2
  logic                 s2_valid_q, s2_ready;
  logic signed [RW-1:0] s2_r_d, s2_r_q;
  rpc_pkg::cordic_t     s2_q;
  // stage 3
  logic                 s3_valid_q, s3_ready;
  rpc_pkg::cordic_t     s3_d, s3_q;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // ---- stage 1: decode, fold left half-plane, first digit step of mod 360
  logic signed [DW-1:0] a_in, b_in;
  logic signed [XW-1:0] ax, by;
  logic [MW-1:0]        w, q;
  logic [2*MW-1:0]      w_prod;

  always_comb begin
    a_in   = in_data_i.first_value;
    b_in   = in_data_i.second_value;
    ax     = XW'(a_in) <<< rpc_pkg::GUARD_BITS;
    by     = XW'(b_in) <<< rpc_pkg::GUARD_BITS;
    w      = b_in[DW-1:MSH];
    w_prod = (2*MW)'(w) * (2*MW)'(rpc_pkg::MOD_RECIP);
    q      = w_prod[2*MW-1:MW];
    // q is exact or one short, so the remainder stays below twice the divisor
    s1_rem_d = w - MW'(q * rpc_pkg::MOD_DIV);

    s1_d          = '0;
    s1_d.a        = a_in;
    s1_d.b        = b_in;
    s1_d.ctl.zero = (a_in == '0) && (b_in == '0);
    unique case (in_data_i.func)
      rpc_pkg::FUNC_RECT: begin
        s1_d.ctl.rect = 1'b1;
        if (a_in[DW-1]) begin
          s1_d.x = -ax;
          s1_d.y = -by;
          s1_d.z = rpc_pkg::DEG180_Z;
        end else begin
          s1_d.x = ax;
          s1_d.y = by;
        end
      end
      rpc_pkg::FUNC_POLAR: begin
        s1_d.x = ax;
      end
      default: begin
        s1_d.ctl.err = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q     <= s1_d;
      s1_rem_q <= s1_rem_d;
      s1_low_q <= in_data_i.second_value[MSH-1:0];
      s1_neg_q <= in_data_i.second_value[DW-1];
    end
  end

  // ---- stage 2: finish mod 360, wrap into (-180,180]
  logic [MW-1:0]        rem;
  logic signed [RW-1:0] u_mod, t_mod;

  always_comb begin
    rem    = (s1_rem_q >= rpc_pkg::MOD_DIV) ? s1_rem_q - rpc_pkg::MOD_DIV : s1_rem_q;
    u_mod  = RW'({rem[rpc_pkg::REM_W-1:0], s1_low_q});
    t_mod  = s1_neg_q ? u_mod - rpc_pkg::WRAP_OFF : u_mod;
    s2_r_d = (t_mod > rpc_pkg::HALF_R) ? t_mod - rpc_pkg::FULL_R : t_mod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_q   <= s1_q;
      s2_r_q <= s2_r_d;
    end
  end

  // ---- stage 3: rotation angle in Q32, fold into [-90,90]
  logic signed [ZW-1:0] z_rot;
  logic signed [XW-1:0] x_rot;

  always_comb begin
    z_rot = ZW'(s2_r_q) <<< (rpc_pkg::ANG_FRAC - rpc_pkg::FRAC_BITS);
    x_rot = s2_q.x;
    s3_d  = s2_q;
    if (!s2_q.ctl.rect) begin
      s3_d.z = z_rot;
      if (z_rot > rpc_pkg::DEG90_Z) begin
        s3_d.x = '0;
        s3_d.y = x_rot;
        s3_d.z = z_rot - rpc_pkg::DEG90_Z;
      end else if (z_rot < rpc_pkg::NEG_DEG90_Z) begin
        s3_d.x = '0;
        s3_d.y = -x_rot;
        s3_d.z = z_rot + rpc_pkg::DEG90_Z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = s3_q;

endmodule

// ===== rtl/core/rpc_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// rpc_cordic_stage: one registered CORDIC micro-rotation
// Vectoring drives y to zero, rotation drives the residual angle to zero.
// ----------------------------------------------------------------------------
module rpc_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rpc_pkg::cordic_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rpc_pkg::cordic_t out_data_o
);

  localparam int XW = rpc_pkg::XY_W;
  localparam int ZW = rpc_pkg::Z_W;
  localparam logic signed [ZW-1:0] ATAN_STEP = rpc_pkg::ATAN_DEG_Q32[IDX][ZW-1:0];

  logic                 valid_q, ready;
  rpc_pkg::cordic_t     data_d, data_q;
  logic signed [XW-1:0] x_in, y_in, x_sh, y_sh;
  logic signed [ZW-1:0] z_in;
  logic                 plus;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  always_comb begin
    x_in = in_data_i.x;
    y_in = in_data_i.y;
    z_in = in_data_i.z;
    x_sh = x_in >>> IDX;
    y_sh = y_in >>> IDX;
    plus = in_data_i.ctl.rect ? !y_in[XW-1] : z_in[ZW-1];
    data_d = in_data_i;
    if (plus) begin
      data_d.x = x_in + y_sh;
      data_d.y = y_in - x_sh;
      data_d.z = z_in + ATAN_STEP;
    end else begin
      data_d.x = x_in - y_sh;
      data_d.y = y_in + x_sh;
      data_d.z = z_in - ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== rtl/core/rpc_post.sv =====
// ----------------------------------------------------------------------------
// rpc_post: gain removal, angle rounding and result assembly
// Four stages: magnitude/round, multiply by 1/K, sum/round, saturate/select.
// ----------------------------------------------------------------------------
module rpc_post (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpc_pkg::cordic_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpc_pkg::out_item_t out_data_o
);

  localparam int DW   = rpc_pkg::DATA_WIDTH;
  localparam int XW   = rpc_pkg::XY_W;
  localparam int ZW   = rpc_pkg::Z_W;
  localparam int RW   = rpc_pkg::ANG_R_W;
  localparam int MW   = rpc_pkg::MUL_W;
  localparam int GB   = rpc_pkg::GUARD_BITS;
  localparam int SH   = rpc_pkg::ANG_FRAC - rpc_pkg::FRAC_BITS;
  localparam int SW   = XW + 1;
  localparam int PW   = SW - GB;
  localparam logic [SW-1:0] ROUND_G = SW'(64'd1 << (GB - 1));
  localparam logic [PW-1:0] MAX_MAG = PW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [PW-1:0] MIN_MAG = PW'(64'd1 << (DW - 1));

  function automatic logic signed [DW-1:0] sat_mag(input logic neg, input logic [PW-1:0] p);
    logic signed [DW-1:0] r;
    if (neg) begin
      r = (p > MIN_MAG) ? {1'b1, {(DW-1){1'b0}}} : -p[DW-1:0];
    end else begin
      r = (p > MAX_MAG) ? {1'b0, {(DW-1){1'b1}}} : p[DW-1:0];
    end
    return r;
  endfunction

  logic p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q;
  logic p1_ready, p2_ready, p3_ready, p4_ready;

  assign p4_ready   = !p4_valid_q || out_ready_i;
  assign p3_ready   = !p3_valid_q || p4_ready;
  assign p2_ready   = !p2_valid_q || p3_ready;
  assign p1_ready   = !p1_valid_q || p2_ready;
  assign in_ready_o = p1_ready;

  // ---- P1: absolute values, angle rounding to field format
  rpc_pkg::ctl_t        p1_ctl_q;
  logic signed [DW-1:0] p1_a_q, p1_b_q;
  logic                 p1_xneg_q, p1_yneg_q;
  logic [XW-1:0]        p1_xabs_q, p1_yabs_q;
  logic signed [RW-1:0] p1_ang_q;
  logic signed [XW-1:0] x_in, y_in;
  logic signed [ZW-1:0] z_rnd;

  always_comb begin
    x_in  = in_data_i.x;
    y_in  = in_data_i.y;
    z_rnd = in_data_i.z + rpc_pkg::ROUND_Z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (p1_ready) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && p1_ready) begin
      p1_ctl_q  <= in_data_i.ctl;
      p1_a_q    <= in_data_i.a;
      p1_b_q    <= in_data_i.b;
      p1_xneg_q <= x_in[XW-1];
      p1_yneg_q <= y_in[XW-1];
      p1_xabs_q <= x_in[XW-1] ? -x_in : x_in;
      p1_yabs_q <= y_in[XW-1] ? -y_in : y_in;
      p1_ang_q  <= z_rnd[ZW-1:SH];
    end
  end

  // ---- P2: partial products of |v| * 1/K, angle wrap into (-180,180]
  rpc_pkg::ctl_t        p2_ctl_q;
  logic signed [DW-1:0] p2_a_q, p2_b_q;
  logic                 p2_xneg_q, p2_yneg_q;
  logic [XW-1:0]        p2_xhi_q, p2_yhi_q;
  logic [2*MW-1:0]      p2_xlo_q, p2_ylo_q;
  logic signed [RW-1:0] p2_ang_d, p2_ang_q;

  always_comb begin
    if (p1_ang_q > rpc_pkg::HALF_R) begin
      p2_ang_d = p1_ang_q - rpc_pkg::FULL_R;
    end else if (p1_ang_q <= rpc_pkg::NEG_HALF_R) begin
      p2_ang_d = p1_ang_q + rpc_pkg::FULL_R;
    end else begin
      p2_ang_d = p1_ang_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (p2_ready) begin
      p2_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_valid_q && p2_ready) begin
      p2_ctl_q  <= p1_ctl_q;
      p2_a_q    <= p1_a_q;
      p2_b_q    <= p1_b_q;
      p2_xneg_q <= p1_xneg_q;
      p2_yneg_q <= p1_yneg_q;
      p2_xhi_q  <= XW'(p1_xabs_q[XW-1:MW]) * XW'(rpc_pkg::INV_GAIN);
      p2_yhi_q  <= XW'(p1_yabs_q[XW-1:MW]) * XW'(rpc_pkg::INV_GAIN);
      p2_xlo_q  <= (2*MW)'(p1_xabs_q[MW-1:0]) * (2*MW)'(rpc_pkg::INV_GAIN);
      p2_ylo_q  <= (2*MW)'(p1_yabs_q[MW-1:0]) * (2*MW)'(rpc_pkg::INV_GAIN);
      p2_ang_q  <= p2_ang_d;
    end
  end

  // ---- P3: floor of the full product, round half away from zero
  rpc_pkg::ctl_t        p3_ctl_q;
  logic signed [DW-1:0] p3_a_q, p3_b_q, p3_ang_q;
  logic                 p3_xneg_q, p3_yneg_q;
  logic [PW-1:0]        p3_xmag_q, p3_ymag_q;
  logic [SW-1:0]        xsum, ysum;

  always_comb begin
    xsum = SW'(p2_xhi_q) + SW'(p2_xlo_q[2*MW-1:MW]) + ROUND_G;
    ysum = SW'(p2_yhi_q) + SW'(p2_ylo_q[2*MW-1:MW]) + ROUND_G;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_valid_q <= 1'b0;
    end else if (p3_ready) begin
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_valid_q && p3_ready) begin
      p3_ctl_q  <= p2_ctl_q;
      p3_a_q    <= p2_a_q;
      p3_b_q    <= p2_b_q;
      p3_xneg_q <= p2_xneg_q;
      p3_yneg_q <= p2_yneg_q;
      p3_xmag_q <= xsum[SW-1:GB];
      p3_ymag_q <= ysum[SW-1:GB];
      p3_ang_q  <= DW'(p2_ang_q);
    end
  end

  // ---- P4: saturate, select by mode, output register
  rpc_pkg::out_item_t   p4_d, p4_q;
  logic signed [DW-1:0] x_sat, y_sat;

  always_comb begin
    x_sat = sat_mag(p3_xneg_q, p3_xmag_q);
    y_sat = sat_mag(p3_yneg_q, p3_ymag_q);
    p4_d  = '0;
    if (p3_ctl_q.err) begin
      p4_d.mode_error = 1'b1;
    end else if (p3_ctl_q.rect) begin
      p4_d.x_out = p3_a_q;
      p4_d.y_out = p3_b_q;
      if (!p3_ctl_q.zero) begin
        p4_d.magnitude_out = x_sat;
        p4_d.angle_out     = p3_ang_q;
      end
    end else begin
      p4_d.x_out         = x_sat;
      p4_d.y_out         = y_sat;
      p4_d.magnitude_out = p3_a_q;
      p4_d.angle_out     = p3_b_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_valid_q <= 1'b0;
    end else if (p4_ready) begin
      p4_valid_q <= p3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_valid_q && p4_ready) begin
      p4_q <= p4_d;
    end
  end

  assign out_valid_o = p4_valid_q;
  assign out_data_o  = p4_q;

endmodule
